// File: rtl/core/sorted_list_table_macros.svh
// ---------------------------------------------------------------------------
// Sorted list table assertion macros
// Shared concurrent assertion forms for the sorted list table.
// ---------------------------------------------------------------------------
`ifndef SORTED_LIST_TABLE_MACROS_SVH
`define SORTED_LIST_TABLE_MACROS_SVH

// same-cycle implication
`define SLTB_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SLTB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/sltb_pkg.sv
// ---------------------------------------------------------------------------
// Sorted list table package
// Operation codes, result layout and cell control type.
// ---------------------------------------------------------------------------
package sltb_pkg;

  localparam int unsigned KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

  localparam int unsigned KEY_FIELD_W = 32;
  localparam int unsigned CNT_FIELD_W = 5;
  localparam int unsigned IN_DATA_W   = 32;
  localparam int unsigned OUT_DATA_W  = 40;

  typedef struct packed {
    logic cmp;  // latch compare flags against the incoming key
    logic ins;  // open a slot and write the key
    logic rem;  // close the slot of the first equal key
  } sltb_ctl_t;

endpackage

// File: rtl/core/sltb_cell.sv
// ---------------------------------------------------------------------------
// Sorted list table cell
// Holds one key, compares it with the broadcast key and shifts it to or from
// its neighbors on insert and remove.
// ---------------------------------------------------------------------------
module sltb_cell #(
  parameter int unsigned KEY_W = 32,
  parameter int unsigned CNT_W = 5,
  parameter int unsigned INDEX = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sltb_pkg::sltb_ctl_t ctl_i,
  input  logic [KEY_W-1:0]    cmp_key_i,
  input  logic [KEY_W-1:0]    ins_key_i,
  input  logic [CNT_W-1:0]    count_i,
  input  logic [KEY_W-1:0]    left_key_i,
  input  logic [KEY_W-1:0]    right_key_i,
  input  logic                left_lt_d_i,
  input  logic                left_lt_q_i,
  output logic [KEY_W-1:0]    key_o,
  output logic                lt_d_o,
  output logic                lt_q_o,
  output logic                hit_o
);
  import sltb_pkg::*;

  logic [KEY_W-1:0] key_q;
  logic             lt_q;
  logic             hit_q;
  logic             occupied;
  logic             lt_d;
  logic             hit_d;

  always_comb begin
    occupied = (CNT_W'(INDEX) < count_i);
    lt_d     = occupied && (key_q < cmp_key_i);
    hit_d    = occupied && (key_q == cmp_key_i) && left_lt_d_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q  <= 1'b0;
      hit_q <= 1'b0;
    end else if (ctl_i.cmp) begin
      lt_q  <= lt_d;
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ins && !lt_q) begin
      key_q <= left_lt_q_i ? ins_key_i : left_key_i;
    end else if (ctl_i.rem && !lt_q) begin
      key_q <= right_key_i;
    end
  end

  assign key_o  = key_q;
  assign lt_d_o = lt_d;
  assign lt_q_o = lt_q;
  assign hit_o  = hit_q;

endmodule

// File: rtl/core/sorted_list_table.sv
// ---------------------------------------------------------------------------
// Sorted list table
// Keeps up to DEPTH keys in ascending order in a row of cells; inserts,
// removes the first equal key, or searches, one operation per transaction.
//
//   channel  dir  tdata                                   tuser
//   s_axis   in   key_value[31:0]                         kind[1:0]
//   m_axis   out  success, matched_key, entry_count, is_empty  -
//
// In each transaction the cells latch their compare flags at acceptance,
// then, in the update state, shift one place and write the result register.
// The next transaction is taken once the result register is free or drains.
// Reset clears the entry count and control; cell keys are left unset.
// A stalled m_axis holds its result and blocks further s_axis transactions.
// ---------------------------------------------------------------------------
`include "sorted_list_table_macros.svh"

module sorted_list_table #(
  parameter int unsigned DEPTH    = 16,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [31:0] key_value
  input  logic [sltb_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [1:0] kind
  input  logic [sltb_pkg::KIND_W-1:0]      s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] success, [32:1] matched_key, [37:33] entry_count, [38] is_empty,
  // [39] zero
  output logic [sltb_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import sltb_pkg::*;

  localparam int unsigned KW    = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_UPD  = 1'b1;

  logic              state_q, state_d;
  logic [KIND_W-1:0] kind_q;
  logic [KW-1:0]     key_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  logic              in_acc;
  logic              found;
  logic              not_full;
  logic              res_success;
  logic [KW-1:0]     res_key;
  sltb_ctl_t         ctl;
  logic [KW-1:0]     in_key;

  logic [KW-1:0]     key_arr  [DEPTH];
  logic [DEPTH-1:0]  lt_d_vec;
  logic [DEPTH-1:0]  lt_q_vec;
  logic [DEPTH-1:0]  hit_vec;

  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_key        = s_axis_tdata[KW-1:0];

  always_comb begin
    found    = |hit_vec;
    not_full = (count_q != FULL_CNT);
    ctl.cmp  = in_acc;
    ctl.ins  = (state_q == ST_UPD) && (kind_q == KIND_INSERT) && not_full;
    ctl.rem  = (state_q == ST_UPD) && (kind_q == KIND_REMOVE) && found;
    count_d  = count_q;
    if (ctl.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctl.rem) begin
      count_d = count_q - CNT_W'(1);
    end
    case (kind_q)
      KIND_INSERT: res_success = not_full;
      KIND_REMOVE: res_success = found;
      KIND_SEARCH: res_success = found;
      default:     res_success = 1'b0;
    endcase
    res_key = ((kind_q == KIND_REMOVE || kind_q == KIND_SEARCH) && found) ? key_q : '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_UPD;
      ST_UPD:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [KW-1:0] left_key;
    logic [KW-1:0] right_key;
    logic          left_lt_d;
    logic          left_lt_q;

    if (g == 0) begin : g_first
      assign left_key  = key_arr[g];
      assign left_lt_d = 1'b1;
      assign left_lt_q = 1'b1;
    end else begin : g_inner
      assign left_key  = key_arr[g-1];
      assign left_lt_d = lt_d_vec[g-1];
      assign left_lt_q = lt_q_vec[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_key = key_arr[g];
    end else begin : g_body
      assign right_key = key_arr[g+1];
    end

    sltb_cell #(
      .KEY_W (KW),
      .CNT_W (CNT_W),
      .INDEX (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .cmp_key_i   (in_key),
      .ins_key_i   (key_q),
      .count_i     (count_q),
      .left_key_i  (left_key),
      .right_key_i (right_key),
      .left_lt_d_i (left_lt_d),
      .left_lt_q_i (left_lt_q),
      .key_o       (key_arr[g]),
      .lt_d_o      (lt_d_vec[g]),
      .lt_q_o      (lt_q_vec[g]),
      .hit_o       (hit_vec[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (state_q == ST_UPD) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= s_axis_tuser;
      key_q  <= in_key;
    end
    if (state_q == ST_UPD) begin
      out_data_q <= {1'b0,
                     (count_d == '0),
                     CNT_FIELD_W'(count_d),
                     KEY_FIELD_W'(res_key),
                     res_success};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `SLTB_ASSERT_NOW(a_count_range, clk_i, rst_ni, 1'b1, count_q <= FULL_CNT, "count above depth")
  `SLTB_ASSERT_NOW(a_hit_unique, clk_i, rst_ni, 1'b1, $onehot0(hit_vec), "several first hits")
  `SLTB_ASSERT_NEXT(a_acc_update, clk_i, rst_ni, in_acc, state_q == ST_UPD, "no update after accept")
  `SLTB_ASSERT_NOW(a_out_free, clk_i, rst_ni, state_q == ST_UPD, !out_valid_q, "result register busy")
  `SLTB_ASSERT_NEXT(a_count_hold, clk_i, rst_ni, state_q == ST_IDLE, $stable(count_q), "count moved")

endmodule
